// ===== hdl/mcid_pkg.sv =====
// Package for the multi-channel input debouncer.
// Shared widths, configuration register indexes and the lane control type.
// No dependencies.
package mcid_pkg;

    localparam int NUM_CHANNELS = 8;   // lanes built, 1..8
    localparam int DATA_W       = 8;   // pin and status vector width
    localparam int LIMIT_W      = 8;   // per-channel tick limit width
    localparam int CNT_FIELD_W  = 4;   // channel_count register width
    localparam int CFG_DATA_W   = 64;  // widest register
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT  = 2'd0,
        CFG_INVERT_MASK    = 2'd1,
        CFG_ASSERT_LIMITS  = 2'd2,
        CFG_RELEASE_LIMITS = 2'd3
    } cfg_addr_t;

    // Per-lane control from the top level for one tick.
    typedef struct packed {
        logic step;    // transaction accepted and channel is in range
        logic active;  // pin level after optional inversion
    } lane_ctrl_t;

endpackage

// ===== hdl/mcid_lane.sv =====
// One debounce lane: assert/release counters and the debounced status bit.
// Depends on mcid_pkg.
module mcid_lane
    import mcid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic [LIMIT_W-1:0] assert_limit,
    input  logic [LIMIT_W-1:0] release_limit,
    output logic               status_next,
    output logic               status
);

    logic [LIMIT_W-1:0] assert_cnt_reg;
    logic [LIMIT_W-1:0] assert_cnt_next;
    logic [LIMIT_W-1:0] release_cnt_reg;
    logic [LIMIT_W-1:0] release_cnt_next;
    logic               status_reg;

    always_comb
    begin
        assert_cnt_next  = assert_cnt_reg;
        release_cnt_next = release_cnt_reg;
        status_next      = status_reg;
        if (ctrl.step)
        begin
            if (ctrl.active)
            begin
                release_cnt_next = '0;
                if (assert_cnt_reg < assert_limit)
                    assert_cnt_next = assert_cnt_reg + LIMIT_W'(1);
                else
                    status_next = 1'b1;
            end
            else
            begin
                assert_cnt_next = '0;
                if (release_cnt_reg < release_limit)
                    release_cnt_next = release_cnt_reg + LIMIT_W'(1);
                else
                    status_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assert_cnt_reg  <= '0;
            release_cnt_reg <= '0;
            status_reg      <= 1'b0;
        end
        else
        begin
            assert_cnt_reg  <= assert_cnt_next;
            release_cnt_reg <= release_cnt_next;
            status_reg      <= status_next;
        end
    end

    assign status = status_reg;

    // only one direction can be counting at a time
    a_cnt_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(assert_cnt_reg != '0 && release_cnt_reg != '0))
        else $error("both debounce counters nonzero");

    a_status_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && ctrl.active && !status_reg && assert_cnt_reg >= assert_limit)
        |=> status_reg)
        else $error("status not set at assert limit");

    a_status_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status_reg) |-> $past(ctrl.step && !ctrl.active))
        else $error("status cleared without an inactive tick");

endmodule

// ===== hdl/mcid_merge.sv =====
// Merge stage: gathers lane status into the result vector and holds it in a
// two-entry output register (output stage plus skid). Depends on mcid_pkg.
module mcid_merge
    import mcid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              push_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                    if (push)
                        out_data_reg <= push_data;
                end
            end
            else if (push)
            begin
                if (out_valid_reg)
                begin
                    skid_data_reg  <= push_data;
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_data_reg  <= push_data;
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output stage");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("transaction pushed into full output stage");

    a_out_drop_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(pop))
        else $error("result dropped without being taken");

endmodule

// ===== hdl/multi_channel_input_debouncer_core.sv =====
// All channel lanes update in parallel; results are registered in the merge stage.
// Throughput: one pin vector per cycle while the skid entry is empty.
// While a result is stalled, the two-entry output stage takes one more transaction.
// Reset (async, rst_n low): counters, status bits and registers clear to zero.
// Top level of the multi-channel input debouncer: config registers, lanes, merge.
// Depends on mcid_pkg, mcid_lane and mcid_merge.
module multi_channel_input_debouncer_core
    import mcid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] pin_levels
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // [7:0] debounced_levels
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_FIELD_W-1:0] channel_count_reg;
    logic [DATA_W-1:0]      invert_mask_reg;
    logic [CFG_DATA_W-1:0]  assert_limits_reg;
    logic [CFG_DATA_W-1:0]  release_limits_reg;

    logic [CNT_FIELD_W-1:0] count_sat;
    logic                   in_accept;
    logic                   merge_ready;
    logic [DATA_W-1:0]      active_vec;
    logic [DATA_W-1:0]      status_next_vec;
    logic [DATA_W-1:0]      status_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg  <= '0;
            invert_mask_reg    <= '0;
            assert_limits_reg  <= '0;
            release_limits_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr_t'(cfg_index))
                CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_data[CNT_FIELD_W-1:0];
                CFG_INVERT_MASK:    invert_mask_reg    <= cfg_data[DATA_W-1:0];
                CFG_ASSERT_LIMITS:  assert_limits_reg  <= cfg_data;
                CFG_RELEASE_LIMITS: release_limits_reg <= cfg_data;
            endcase
        end
    end

    assign count_sat = (channel_count_reg > CNT_FIELD_W'(NUM_CHANNELS))
                     ? CNT_FIELD_W'(NUM_CHANNELS) : channel_count_reg;

    assign s_axis_tready = merge_ready;
    assign in_accept     = s_axis_tvalid && merge_ready;
    assign active_vec    = s_axis_tdata ^ invert_mask_reg;

    genvar ch;
    generate
        for (ch = 0; ch < NUM_CHANNELS; ch++)
        begin : g_lane
            lane_ctrl_t lane_ctrl;

            assign lane_ctrl.step   = in_accept && (CNT_FIELD_W'(ch) < count_sat);
            assign lane_ctrl.active = active_vec[ch];

            mcid_lane u_lane (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (lane_ctrl),
                .assert_limit  (assert_limits_reg[ch*LIMIT_W +: LIMIT_W]),
                .release_limit (release_limits_reg[ch*LIMIT_W +: LIMIT_W]),
                .status_next   (status_next_vec[ch]),
                .status        (status_vec[ch])
            );
        end
        // channels without a lane never change and read as zero
        for (ch = NUM_CHANNELS; ch < DATA_W; ch++)
        begin : g_unused
            assign status_next_vec[ch] = 1'b0;
            assign status_vec[ch]      = 1'b0;
        end
    endgenerate

    mcid_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_data  (status_next_vec),
        .push_ready (merge_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

    // with no channel selected a tick leaves status untouched
    a_idle_channels_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && count_sat == '0) |=> status_vec == $past(status_vec))
        else $error("status changed with no channels enabled");

    a_push_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> status_vec == $past(status_next_vec))
        else $error("lane status diverged from pushed result");

    a_hold_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(status_vec))
        else $error("lane status changed without a transaction");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for multi_channel_input_debouncer_core.
// Drives pin vectors through the input stream, predicts debounced status in-line.
// Depends on mcid_pkg and the core RTL.
module tb;
    import mcid_pkg::*;

    localparam int STALL_LIMIT = 4000;  // cycles with no transaction anywhere
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS    = 25;
    localparam int NUM_PHASES  = 8;
    localparam int SHORT_ITEMS = 110;
    localparam int LONG_ITEMS  = 340;
    localparam int LONG_PHASE  = 5;

    typedef struct {
        bit                    is_write;
        cfg_addr_t             idx;
        logic [CFG_DATA_W-1:0] val;
        logic [DATA_W-1:0]     pins;
        bit                    known;
        logic [DATA_W-1:0]     want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;     // [7:0] pin_levels
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;          // [7:0] debounced_levels
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state and shadow registers
    logic [LIMIT_W-1:0]     assert_count [NUM_CHANNELS];
    logic [LIMIT_W-1:0]     release_count [NUM_CHANNELS];
    logic [DATA_W-1:0]      status_vec;
    logic [CNT_FIELD_W-1:0] lanes_reg;
    logic [DATA_W-1:0]      invert_reg;
    logic [CFG_DATA_W-1:0]  assert_lim_reg;
    logic [CFG_DATA_W-1:0]  release_lim_reg;

    logic [DATA_W-1:0] expected_levels [$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_writes = 0;
    int quiet_cycles = 0;
    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // channel count is zero after reset: nothing moves
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'hFF, 1'b1, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b1, 8'h00},
        // count above 8 saturates; zero limits follow the level at once
        '{1'b1, CFG_CHANNEL_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_INVERT_MASK, 64'hA5A5_A5A5_A5A5_A50F, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b1, 8'h0F},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'hFF, 1'b1, 8'hF0},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'hA5, 1'b1, 8'hAA},
        // four lanes only; upper lanes keep their status
        '{1'b1, CFG_CHANNEL_COUNT, 64'h0000_0000_0000_0004, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_INVERT_MASK, 64'h0, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_ASSERT_LIMITS, 64'h0202_0202_0202_0202, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_RELEASE_LIMITS, 64'h0101_0101_0101_0101, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h0F, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h0F, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'hFF, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h0F, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h05, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b0, 8'h00},
        // full lane count, 255-tick limits on the top lanes
        '{1'b1, CFG_CHANNEL_COUNT, 64'h0000_0000_0000_0008, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_ASSERT_LIMITS, 64'h00FF_0000_0000_0001, 8'h00, 1'b0, 8'h00},
        '{1'b1, CFG_RELEASE_LIMITS, 64'hFF00_0000_0000_0000, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'hFF, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h00, 1'b0, 8'h00},
        '{1'b0, CFG_CHANNEL_COUNT, 64'h0, 8'h80, 1'b0, 8'h00}
    };

    multi_channel_input_debouncer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One tick of the debouncer: updates counters and status, returns status.
    function automatic logic [DATA_W-1:0] debounce_tick(input logic [DATA_W-1:0] pins);
        int                 lanes;
        logic               active;
        logic [LIMIT_W-1:0] lim;
        lanes = (lanes_reg > NUM_CHANNELS) ? NUM_CHANNELS : int'(lanes_reg);
        for (int ch = 0; ch < lanes; ch++)
        begin
            active = pins[ch] ^ invert_reg[ch];
            if (active)
            begin
                release_count[ch] = '0;
                lim = assert_lim_reg[ch*LIMIT_W +: LIMIT_W];
                if (assert_count[ch] < lim)
                    assert_count[ch] = assert_count[ch] + 1'b1;
                else
                    status_vec[ch] = 1'b1;
            end
            else
            begin
                assert_count[ch] = '0;
                lim = release_lim_reg[ch*LIMIT_W +: LIMIT_W];
                if (release_count[ch] < lim)
                    release_count[ch] = release_count[ch] + 1'b1;
                else
                    status_vec[ch] = 1'b0;
            end
        end
        return status_vec;
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit(input bit long_run);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        if (long_run)
            return (roll < 5) ? 8'd255 : 8'($urandom_range(100, 254));
        if (roll == 1)
            return 8'd255;
        if (roll == 2)
            return 8'($urandom);
        return 8'($urandom_range(1, 6));
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic send_pins(input logic [DATA_W-1:0] pins, input bit known,
                             input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] next_status;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = pins;
        do
            @(posedge clk);
        while (!s_axis_tready);
        next_status = debounce_tick(pins);
        expected_levels.push_back(known ? want : next_status);
        n_sent++;
        @(negedge clk);
    endtask

    // Registers change only once every outstanding status has come back.
    task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] val);
        s_axis_tvalid = 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_CHANNEL_COUNT:  lanes_reg = val[CNT_FIELD_W-1:0];
            CFG_INVERT_MASK:    invert_reg = val[DATA_W-1:0];
            CFG_ASSERT_LIMITS:  assert_lim_reg = val;
            CFG_RELEASE_LIMITS: release_lim_reg = val;
            default: ;
        endcase
        n_writes++;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_levels.size() == 0)
                flag_error($sformatf("unexpected status 0x%02h", m_axis_tdata));
            else
            begin
                if (m_axis_tdata !== expected_levels[0])
                    flag_error($sformatf("debounced_levels expected 0x%02h got 0x%02h",
                                         expected_levels[0], m_axis_tdata));
                void'(expected_levels.pop_front());
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("multi_channel_input_debouncer_core: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        logic [DATA_W-1:0]     held;
        logic [DATA_W-1:0]     flips;
        logic [DATA_W-1:0]     pins;
        logic [CFG_DATA_W-1:0] val;
        int                    flip_div;
        int                    glitch_pct;
        int                    items;
        bit                    long_run;

        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            assert_count[ch]  = '0;
            release_count[ch] = '0;
        end
        status_vec      = '0;
        lanes_reg       = '0;
        invert_reg      = '0;
        assert_lim_reg  = '0;
        release_lim_reg = '0;
        held            = '0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].is_write)
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            else
                send_pins(dir_rows[r].pins, dir_rows[r].known, dir_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            long_run = (p == LONG_PHASE);

            // random upper bits check that the narrow registers ignore them
            val = {$urandom, $urandom};
            if (p == 0)
                val[CNT_FIELD_W-1:0] = 4'd8;
            else if (p == 1 || $urandom_range(0, 3) == 0)
                val[CNT_FIELD_W-1:0] = 4'($urandom_range(9, 15));
            else
                val[CNT_FIELD_W-1:0] = 4'($urandom_range(1, 8));
            if (long_run)
                val[CNT_FIELD_W-1:0] = 4'd8;
            write_reg(CFG_CHANNEL_COUNT, val);
            write_reg(CFG_INVERT_MASK, {$urandom, $urandom});
            for (int b = 0; b < NUM_CHANNELS; b++)
                val[b*LIMIT_W +: LIMIT_W] = pick_limit(long_run);
            write_reg(CFG_ASSERT_LIMITS, val);
            for (int b = 0; b < NUM_CHANNELS; b++)
                val[b*LIMIT_W +: LIMIT_W] = pick_limit(long_run);
            write_reg(CFG_RELEASE_LIMITS, val);

            case (p % 4)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 54; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 54; end
                default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
            endcase

            // held levels with occasional edges, plus one-tick glitches
            flip_div   = long_run ? 400 : $urandom_range(2, 12);
            glitch_pct = long_run ? 2 : 10;
            items      = long_run ? LONG_ITEMS : SHORT_ITEMS;
            for (int i = 0; i < items; i++)
            begin
                flips = '0;
                for (int b = 0; b < DATA_W; b++)
                    flips[b] = ($urandom_range(1, flip_div) == 1);
                held = held ^ flips;
                pins = held;
                if ($urandom_range(0, 99) < glitch_pct)
                    pins = pins ^ 8'($urandom);
                send_pins(pins, 1'b0, 8'h00);
            end
        end

        s_axis_tvalid = 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (expected_levels.size() != 0)
            flag_error($sformatf("%0d status vectors never arrived", expected_levels.size()));

        $display("Sent %0d pin vectors under %0d register writes, compared %0d status vectors",
                 n_sent, n_writes, n_checked);
        $display("Idle/stall mixes: none, sender 54%%, receiver 54%%, both 15%%; %0d errors",
                 errors);
        if (errors == 0)
            $display("multi_channel_input_debouncer_core: match");
        else
            $display("multi_channel_input_debouncer_core: mismatch");
        $finish;
    end

endmodule
